/* rtl/crc8fr_pkg.sv */
// shared types, codes and the crc-8 step for the frame receiver
`timescale 1ns / 1ps
`default_nettype none
package crc8fr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned OutW    = 4 * ByteW;

  localparam logic [ByteW-1:0] HeaderReset = 8'hAA;
  localparam logic [ByteW-1:0] TailReset   = 8'h55;
  localparam logic [ByteW-1:0] CrcPoly     = 8'h07;
  localparam logic [ByteW-1:0] CrcInit     = 8'h00;

  localparam logic [CfgIdxW-1:0] CFG_HEADER = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_TAIL   = 1'b1;

  // frame positions
  localparam logic [PosW-1:0] POS_IDLE = 3'd0;
  localparam logic [PosW-1:0] POS_LEN  = 3'd1;
  localparam logic [PosW-1:0] POS_CMD  = 3'd2;
  localparam logic [PosW-1:0] POS_D0   = 3'd3;
  localparam logic [PosW-1:0] POS_D1   = 3'd4;
  localparam logic [PosW-1:0] POS_D2   = 3'd5;
  localparam logic [PosW-1:0] POS_CRC  = 3'd6;
  localparam logic [PosW-1:0] POS_TAIL = 3'd7;

  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic [ByteW-1:0] data;
  } entry_t;

  function automatic logic [ByteW-1:0] crc8_step(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[ByteW-1]) begin
        v = {v[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[ByteW-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/crc8fr_front.sv */
// front end: header hunt and frame position tagging
`timescale 1ns / 1ps
`default_nettype none
module crc8fr_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [crc8fr_pkg::ByteW-1:0] header_i,
  input  wire logic                      accept_i,
  input  wire logic [crc8fr_pkg::ByteW-1:0] byte_i,
  output logic                           push_o,
  output crc8fr_pkg::entry_t             entry_o
);
  import crc8fr_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;

  always_comb begin
    pos_d = pos_q;
    if (accept_i) begin
      if (pos_q == POS_IDLE) begin
        if (byte_i == header_i) begin
          pos_d = POS_LEN;
        end
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  // header and length bytes carry nothing for the back end
  assign push_o       = accept_i && (pos_q >= POS_CMD);
  assign entry_o.pos  = pos_q;
  assign entry_o.data = byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_IDLE;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/crc8fr_queue.sv */
// two-entry queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module crc8fr_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire crc8fr_pkg::entry_t entry_i,
  output logic                    full_o,
  output logic                    valid_o,
  input  wire logic               pop_i,
  output crc8fr_pkg::entry_t      entry_o
);
  import crc8fr_pkg::*;

  entry_t     mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/crc8fr_back.sv */
// back end: crc accumulation, frame check and result register
`timescale 1ns / 1ps
`default_nettype none
module crc8fr_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [crc8fr_pkg::ByteW-1:0] tail_i,
  input  wire logic                        q_valid_i,
  input  wire crc8fr_pkg::entry_t          q_entry_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [crc8fr_pkg::OutW-1:0]      out_data_o
);
  import crc8fr_pkg::*;

  logic [ByteW-1:0] store_q [4];
  logic [ByteW-1:0] crc_q, crc_d;
  logic [ByteW-1:0] chk_q;
  logic [OutW-1:0]  out_q;
  logic             out_vld_q, out_vld_d;
  logic             load;

  // a tail byte waits while the result register is still held
  assign pop_o = q_valid_i &&
                 ((q_entry_i.pos != POS_TAIL) || !out_vld_q || out_ready_i);
  assign load  = pop_o && (q_entry_i.pos == POS_TAIL) &&
                 (q_entry_i.data == tail_i) && (crc_q == chk_q);

  always_comb begin
    crc_d = crc_q;
    if (pop_o) begin
      if (q_entry_i.pos == POS_CMD) begin
        crc_d = crc8_step(CrcInit, q_entry_i.data);
      end else if (q_entry_i.pos == POS_D0 || q_entry_i.pos == POS_D1 ||
                   q_entry_i.pos == POS_D2) begin
        crc_d = crc8_step(crc_q, q_entry_i.data);
      end
    end
    out_vld_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      unique case (q_entry_i.pos)
        POS_CMD: store_q[0] <= q_entry_i.data;
        POS_D0:  store_q[1] <= q_entry_i.data;
        POS_D1:  store_q[2] <= q_entry_i.data;
        POS_D2:  store_q[3] <= q_entry_i.data;
        POS_CRC: chk_q      <= q_entry_i.data;
        default: ;
      endcase
    end
    if (load) begin
      out_q <= {store_q[3], store_q[2], store_q[1], store_q[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= CrcInit;
      out_vld_q <= 1'b0;
    end else begin
      crc_q     <= crc_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

/* rtl/crc8_frame_receiver.sv */
// top level: fixed-length frame receiver with crc-8 check
//
// channel  dir  fields (lsb first)
// s_axis   in   tdata: rx_byte
// m_axis   out  tdata: command, payload0, payload1, payload2
// cfg      in   index 0 header_byte, index 1 tail_byte
//
// one byte per cycle sustained while the queue has room; with the output ready
// a frame result leaves once its tail byte has passed the two-entry queue and the
// result register, later when the queue still holds an earlier byte.
// a held result stalls only the back end at the next tail byte; the front keeps
// taking bytes until the queue fills. reset clears position, crc and valids.
`timescale 1ns / 1ps
`default_nettype none
module crc8_frame_receiver (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [crc8fr_pkg::ByteW-1:0]   s_axis_tdata,  // rx_byte
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // command, payload0, payload1, payload2
  output logic [crc8fr_pkg::OutW-1:0]         m_axis_tdata,
  input  wire logic                           cfg_we_i,
  input  wire logic [crc8fr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [crc8fr_pkg::ByteW-1:0]   cfg_wdata_i
);
  import crc8fr_pkg::*;

  logic [ByteW-1:0] header_q, tail_q;
  logic             accept, push, q_full, q_valid, pop;
  entry_t           f_entry, q_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderReset;
      tail_q   <= TailReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEADER: header_q <= cfg_wdata_i;
        CFG_TAIL:   tail_q   <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  crc8fr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .header_i (header_q),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .push_o   (push),
    .entry_o  (f_entry)
  );

  crc8fr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (f_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .entry_o (q_entry)
  );

  crc8fr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tail_i      (tail_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire
